FILE: sv/brf_pkg.sv
// ----------------------------------------------------------------------------
// Byte ring FIFO package
// Shared widths, codes and request/response types of the burst byte FIFO.
// ----------------------------------------------------------------------------
package brf_pkg;

  localparam int unsigned StoreDepthDef = 256;
  localparam int unsigned MaxBurstDef   = 8;
  localparam int unsigned ByteW         = 8;
  localparam int unsigned BurstBytes    = 8;
  localparam int unsigned DataW         = ByteW * BurstBytes;
  localparam int unsigned CountW        = 4;
  localparam int unsigned CapW          = 9;
  localparam int unsigned CapReset      = 256;

  typedef enum logic {
    ACT_PUSH = 1'b0,
    ACT_POP  = 1'b1
  } action_e;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_BAD_LEN  = 3'd1,
    ST_NO_SPACE = 3'd2,
    ST_EMPTY    = 3'd3,
    ST_UNDERRUN = 3'd4
  } status_e;

  typedef struct packed {
    action_e             action;
    logic [CountW-1:0]   byte_count;
    logic [DataW-1:0]    data_in;
  } in_req_t;

  typedef struct packed {
    status_e             status;
    logic [CountW-1:0]   moved_count;
    logic [DataW-1:0]    data_out;
    logic [CapW-1:0]     occupancy;
  } out_rsp_t;

endpackage

FILE: sv/brf_lane.sv
// ----------------------------------------------------------------------------
// Byte ring FIFO lane
// One byte-wide storage bank with one write port and a registered read port.
// ----------------------------------------------------------------------------
module brf_lane #(
  parameter int unsigned Rows = 32,
  parameter int unsigned RowW = 5
) (
  input  logic                       clk_i,
  input  logic                       we_i,
  input  logic [RowW-1:0]            waddr_i,
  input  logic [brf_pkg::ByteW-1:0]  wdata_i,
  input  logic                       re_i,
  input  logic [RowW-1:0]            raddr_i,
  output logic [brf_pkg::ByteW-1:0]  rdata_o
);
  import brf_pkg::*;

  logic [ByteW-1:0] mem_q [Rows];
  logic [ByteW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: sv/brf_merge.sv
// ----------------------------------------------------------------------------
// Byte ring FIFO merge
// Rotate the lane read bytes into request order and zero the unused bytes.
// ----------------------------------------------------------------------------
module brf_merge #(
  parameter int unsigned MAX_BURST = brf_pkg::MaxBurstDef,
  parameter int unsigned LaneW     = 3
) (
  input  logic [MAX_BURST-1:0][brf_pkg::ByteW-1:0] lane_data_i,
  input  logic [LaneW-1:0]                         start_lane_i,
  input  logic [brf_pkg::CountW-1:0]               count_i,
  output logic [brf_pkg::DataW-1:0]                data_o
);
  import brf_pkg::*;

  localparam logic [LaneW:0] LaneNum = (LaneW+1)'(MAX_BURST);

  for (genvar i = 0; i < BurstBytes; i++) begin : g_byte
    if (i < MAX_BURST) begin : g_used
      localparam logic [LaneW:0]    ByteIdx = (LaneW+1)'(i);
      localparam logic [CountW-1:0] ByteCnt = CountW'(i);
      logic [LaneW:0] sum;
      logic [LaneW:0] sel;

      always_comb begin
        sum = {1'b0, start_lane_i} + ByteIdx;
        sel = sum;
        if (sum >= LaneNum) begin
          sel = sum - LaneNum;
        end
      end

      assign data_o[i*ByteW +: ByteW] =
        (ByteCnt < count_i) ? lane_data_i[sel[LaneW-1:0]] : '0;
    end else begin : g_unused
      assign data_o[i*ByteW +: ByteW] = '0;
    end
  end

endmodule

FILE: sv/byte_ring_fifo_burst.sv
// ----------------------------------------------------------------------------
// Byte ring FIFO with burst requests
// Circular byte FIFO taking all-or-nothing pushes and pops of 1 to MAX_BURST
// bytes per request.
// ----------------------------------------------------------------------------
// One request is taken per clock cycle while in_stall_o is low; its response
// appears in the output register on the next cycle, and a new request is taken
// while a response waits as long as out_stall_i is low. The store is split into
// MAX_BURST byte lanes, each with one write and one registered read port, so
// that a whole burst is written or read at once. Writing the capacity register
// empties the FIFO at once and keeps the stored bytes; there is no clearing
// pass after reset.
// ----------------------------------------------------------------------------
module byte_ring_fifo_burst #(
  parameter int unsigned STORE_DEPTH = brf_pkg::StoreDepthDef,
  parameter int unsigned MAX_BURST   = brf_pkg::MaxBurstDef
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [brf_pkg::CapW-1:0]   cfg_wdata_i,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  brf_pkg::in_req_t           in_req_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output brf_pkg::out_rsp_t          out_rsp_o
);
  import brf_pkg::*;

  localparam int unsigned LaneW    = (MAX_BURST > 1) ? $clog2(MAX_BURST) : 1;
  localparam int unsigned Rows     = (STORE_DEPTH + MAX_BURST - 1) / MAX_BURST;
  localparam int unsigned RowW     = (Rows > 1) ? $clog2(Rows) : 1;
  localparam int unsigned CapLimit = (STORE_DEPTH < 511) ? STORE_DEPTH : 511;

  localparam logic [LaneW:0]    LaneNum  = (LaneW+1)'(MAX_BURST);
  localparam logic [RowW-1:0]   RowLast  = RowW'(Rows - 1);
  localparam logic [CountW-1:0] BurstMax = CountW'(MAX_BURST);
  localparam logic [CapW-1:0]   CapMax   = CapW'(CapLimit);

  logic [CapW-1:0]   capacity_q;
  logic [CapW-1:0]   fill_q, fill_d;
  logic [LaneW-1:0]  wr_lane_q, wr_lane_d, rd_lane_q, rd_lane_d;
  logic [RowW-1:0]   wr_row_q, wr_row_d, rd_row_q, rd_row_d;
  logic [RowW-1:0]   wr_row_inc, rd_row_inc;

  logic [CapW-1:0]   cap_eff, room, cnt_ext;
  logic [CountW-1:0] count;
  logic              accept, do_push, do_pop;
  status_e           status_d;
  logic [CountW-1:0] moved_d;
  logic [LaneW:0]    wr_sum, rd_sum;

  logic                                 out_valid_q;
  status_e                              status_q;
  logic [CountW-1:0]                    moved_q;
  logic [CapW-1:0]                      occ_q;
  logic [LaneW-1:0]                     pop_start_q;
  logic [CountW-1:0]                    pop_cnt_q;
  logic [MAX_BURST-1:0][ByteW-1:0]      lane_rdata;
  logic [DataW-1:0]                     merged;

  assign in_stall_o = out_valid_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign count      = in_req_i.byte_count;
  assign cnt_ext    = CapW'(count);

  assign wr_row_inc = (wr_row_q == RowLast) ? '0 : wr_row_q + RowW'(1);
  assign rd_row_inc = (rd_row_q == RowLast) ? '0 : rd_row_q + RowW'(1);

  always_comb begin
    cap_eff = capacity_q;
    if (capacity_q == '0) begin
      cap_eff = CapW'(1);
    end else if (capacity_q > CapMax) begin
      cap_eff = CapMax;
    end
    room     = cap_eff - fill_q;
    status_d = ST_OK;
    do_push  = 1'b0;
    do_pop   = 1'b0;
    if (in_req_i.action == ACT_PUSH) begin
      if (count == '0 || count > BurstMax || cnt_ext > cap_eff) begin
        status_d = ST_BAD_LEN;
      end else if (cnt_ext > room) begin
        status_d = ST_NO_SPACE;
      end else begin
        do_push = 1'b1;
      end
    end else begin
      if (fill_q == '0 || count == '0) begin
        status_d = ST_EMPTY;
      end else if (count > BurstMax) begin
        status_d = ST_BAD_LEN;
      end else if (cnt_ext > fill_q) begin
        status_d = ST_UNDERRUN;
      end else begin
        do_pop = 1'b1;
      end
    end
    moved_d = (do_push || do_pop) ? count : '0;
    fill_d  = fill_q;
    if (do_push) begin
      fill_d = fill_q + cnt_ext;
    end else if (do_pop) begin
      fill_d = fill_q - cnt_ext;
    end
  end

  // advance lane/row pointers by the burst length
  always_comb begin
    wr_sum    = {1'b0, wr_lane_q} + (LaneW+1)'(count);
    rd_sum    = {1'b0, rd_lane_q} + (LaneW+1)'(count);
    wr_lane_d = wr_lane_q;
    wr_row_d  = wr_row_q;
    rd_lane_d = rd_lane_q;
    rd_row_d  = rd_row_q;
    if (do_push) begin
      if (wr_sum >= LaneNum) begin
        wr_lane_d = LaneW'(wr_sum - LaneNum);
        wr_row_d  = wr_row_inc;
      end else begin
        wr_lane_d = LaneW'(wr_sum);
      end
    end
    if (do_pop) begin
      if (rd_sum >= LaneNum) begin
        rd_lane_d = LaneW'(rd_sum - LaneNum);
        rd_row_d  = rd_row_inc;
      end else begin
        rd_lane_d = LaneW'(rd_sum);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      capacity_q <= CapW'(CapReset);
      fill_q     <= '0;
      wr_lane_q  <= '0;
      wr_row_q   <= '0;
      rd_lane_q  <= '0;
      rd_row_q   <= '0;
    end else if (cfg_we_i) begin
      capacity_q <= cfg_wdata_i;
      fill_q     <= '0;
      wr_lane_q  <= '0;
      wr_row_q   <= '0;
      rd_lane_q  <= '0;
      rd_row_q   <= '0;
    end else if (accept) begin
      fill_q     <= fill_d;
      wr_lane_q  <= wr_lane_d;
      wr_row_q   <= wr_row_d;
      rd_lane_q  <= rd_lane_d;
      rd_row_q   <= rd_row_d;
    end
  end

  for (genvar k = 0; k < MAX_BURST; k++) begin : g_lane
    localparam logic [LaneW:0] LaneK = (LaneW+1)'(k);
    logic [LaneW:0]  w_off, r_off;
    logic [RowW-1:0] w_row, r_row;
    logic            we, re;

    always_comb begin
      if (LaneK >= {1'b0, wr_lane_q}) begin
        w_off = LaneK - {1'b0, wr_lane_q};
        w_row = wr_row_q;
      end else begin
        w_off = LaneK + LaneNum - {1'b0, wr_lane_q};
        w_row = wr_row_inc;
      end
      if (LaneK >= {1'b0, rd_lane_q}) begin
        r_off = LaneK - {1'b0, rd_lane_q};
        r_row = rd_row_q;
      end else begin
        r_off = LaneK + LaneNum - {1'b0, rd_lane_q};
        r_row = rd_row_inc;
      end
    end

    assign we = accept && do_push && (CountW'(w_off) < count);
    assign re = accept && do_pop && (CountW'(r_off) < count);

    brf_lane #(
      .Rows (Rows),
      .RowW (RowW)
    ) u_lane (
      .clk_i   (clk_i),
      .we_i    (we),
      .waddr_i (w_row),
      .wdata_i (in_req_i.data_in[ByteW*w_off[LaneW-1:0] +: ByteW]),
      .re_i    (re),
      .raddr_i (r_row),
      .rdata_o (lane_rdata[k])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      status_q    <= status_d;
      moved_q     <= moved_d;
      occ_q       <= fill_d;
      pop_start_q <= rd_lane_q;
      pop_cnt_q   <= do_pop ? count : '0;
    end
  end

  brf_merge #(
    .MAX_BURST (MAX_BURST),
    .LaneW     (LaneW)
  ) u_merge (
    .lane_data_i  (lane_rdata),
    .start_lane_i (pop_start_q),
    .count_i      (pop_cnt_q),
    .data_o       (merged)
  );

  assign out_valid_o           = out_valid_q;
  assign out_rsp_o.status      = status_q;
  assign out_rsp_o.moved_count = moved_q;
  assign out_rsp_o.data_out    = merged;
  assign out_rsp_o.occupancy   = occ_q;

  a_fill_in_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= cap_eff)
    else $error("fill level above effective capacity");

  a_push_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && do_push && !cfg_we_i |=> fill_q == $past(fill_q) + $past(cnt_ext))
    else $error("fill level not advanced by push length");

  a_refuse_moves_none: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && status_q != ST_OK |-> moved_q == '0 && merged == '0)
    else $error("refused request reports moved bytes");

endmodule

FILE: tb/sv/brf_burst_checker.sv
// ----------------------------------------------------------------------------
// Burst byte FIFO checker
// Watches the configuration port and the request and response channels of the
// burst byte FIFO, keeps its own image of the ring, the pointers, the fill
// level and the capacity, predicts the response of each accepted request and
// compares the responses in order, field by field. Hands the mismatch count
// and the number of responses still due to the testbench top.
// ----------------------------------------------------------------------------
module brf_burst_checker (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [brf_pkg::CapW-1:0] cfg_wdata_i,
  input  logic                     in_valid_i,
  input  logic                     in_stall_i,
  input  brf_pkg::in_req_t         in_req_i,
  input  logic                     out_valid_i,
  input  logic                     out_stall_i,
  input  brf_pkg::out_rsp_t        out_rsp_i,
  output int unsigned              pending_o,
  output int unsigned              fails_o
);
  import brf_pkg::*;

  localparam int unsigned PtrW = $clog2(StoreDepthDef);

  logic [ByteW-1:0] ring_mem [StoreDepthDef];
  int unsigned      wr_ptr     = 0;
  int unsigned      rd_ptr     = 0;
  int unsigned      fill_level = 0;
  logic [CapW-1:0]  cap_reg    = CapW'(CapReset);
  out_rsp_t         rsp_due_q [$];
  out_rsp_t         rsp_want;
  int unsigned      due_cnt      = 0;
  int unsigned      mismatch_cnt = 0;

  assign pending_o = due_cnt;
  assign fails_o   = mismatch_cnt;

  task automatic report_mismatch(string msg);
    if (mismatch_cnt < 50) begin
      $display("mismatch at %0t: %s", $time, msg);
    end
    mismatch_cnt++;
  endtask

  function automatic out_rsp_t apply_request(in_req_t req);
    out_rsp_t    rsp;
    int unsigned cap_val;
    int unsigned lim;
    int unsigned cnt;
    int unsigned i;
    rsp = '0;
    cap_val = 32'(cap_reg);
    lim = (cap_val == 0) ? 1 : ((cap_val > StoreDepthDef) ? StoreDepthDef : cap_val);
    cnt = 32'(req.byte_count);
    if (req.action == ACT_PUSH) begin
      if (cnt == 0 || cnt > MaxBurstDef || cnt > lim) begin
        rsp.status = ST_BAD_LEN;
      end else if (cnt > lim - fill_level) begin
        rsp.status = ST_NO_SPACE;
      end else begin
        for (i = 0; i < cnt; i++) begin
          ring_mem[wr_ptr[PtrW-1:0]] = req.data_in[8*i +: 8];
          wr_ptr = (wr_ptr + 1 >= lim) ? 0 : wr_ptr + 1;
        end
        fill_level += cnt;
        rsp.status      = ST_OK;
        rsp.moved_count = cnt[CountW-1:0];
      end
    end else begin
      if (fill_level == 0 || cnt == 0) begin
        rsp.status = ST_EMPTY;
      end else if (cnt > MaxBurstDef) begin
        rsp.status = ST_BAD_LEN;
      end else if (cnt > fill_level) begin
        rsp.status = ST_UNDERRUN;
      end else begin
        for (i = 0; i < cnt; i++) begin
          rsp.data_out[8*i +: 8] = ring_mem[rd_ptr[PtrW-1:0]];
          rd_ptr = (rd_ptr + 1 >= lim) ? 0 : rd_ptr + 1;
        end
        fill_level -= cnt;
        rsp.status      = ST_OK;
        rsp.moved_count = cnt[CountW-1:0];
      end
    end
    rsp.occupancy = fill_level[CapW-1:0];
    return rsp;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr     = 0;
      rd_ptr     = 0;
      fill_level = 0;
      cap_reg    = CapW'(CapReset);
      rsp_due_q.delete();
      due_cnt    = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (rsp_due_q.size() == 0) begin
          report_mismatch("response with no request outstanding");
        end else begin
          rsp_want = rsp_due_q.pop_front();
          if (out_rsp_i.status !== rsp_want.status) begin
            report_mismatch($sformatf("status got %0d want %0d",
                                      out_rsp_i.status, rsp_want.status));
          end
          if (out_rsp_i.moved_count !== rsp_want.moved_count) begin
            report_mismatch($sformatf("moved_count got %0d want %0d",
                                      out_rsp_i.moved_count, rsp_want.moved_count));
          end
          if (out_rsp_i.data_out !== rsp_want.data_out) begin
            report_mismatch($sformatf("data_out got %h want %h",
                                      out_rsp_i.data_out, rsp_want.data_out));
          end
          if (out_rsp_i.occupancy !== rsp_want.occupancy) begin
            report_mismatch($sformatf("occupancy got %0d want %0d",
                                      out_rsp_i.occupancy, rsp_want.occupancy));
          end
        end
      end
      if (cfg_we_i) begin
        cap_reg    = cfg_wdata_i;
        wr_ptr     = 0;
        rd_ptr     = 0;
        fill_level = 0;
      end
      if (in_valid_i && !in_stall_i) begin
        rsp_due_q.push_back(apply_request(in_req_i));
      end
      due_cnt = rsp_due_q.size();
    end
  end

endmodule

FILE: tb/sv/tb_byte_ring_fifo_burst.sv
// ----------------------------------------------------------------------------
// Burst byte FIFO testbench
// Drives a directed run through every status and the capacity extremes, then
// phases of random push and pop requests at several capacities, filling and
// draining the ring past the wrap point, with random gaps on the request side
// and random stalls on the response side outside one calm phase. The checker
// beside the block predicts and compares; this top gives the verdict.
// ----------------------------------------------------------------------------
module tb_byte_ring_fifo_burst;
  import brf_pkg::*;

  localparam int unsigned NumPhases = 8;

  logic            clk_i       = 1'b0;
  logic            rst_ni      = 1'b0;
  logic            cfg_we_i    = 1'b0;
  logic [CapW-1:0] cfg_wdata_i = '0;
  logic            in_valid_i  = 1'b0;
  logic            in_stall_o;
  in_req_t         in_req_i    = '0;
  logic            out_valid_o;
  logic            out_stall_i = 1'b0;
  out_rsp_t        out_rsp_o;
  logic            no_idle     = 1'b0;
  int unsigned     pending;
  int unsigned     fails;

  logic [CapW-1:0] phase_cap   [NumPhases] = '{9'd1, 9'd511, 9'd8, 9'd0,
                                               9'd3, 9'd100, 9'd256, 9'd5};
  int unsigned     phase_len   [NumPhases] = '{100, 320, 140, 60, 100, 200, 280, 100};
  logic            phase_calm  [NumPhases] = '{1'b0, 1'b0, 1'b1, 1'b0,
                                               1'b0, 1'b0, 1'b0, 1'b0};

  always #4 clk_i = ~clk_i;

  byte_ring_fifo_burst dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_req_i    (in_req_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_rsp_o   (out_rsp_o)
  );

  brf_burst_checker u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_i  (in_stall_o),
    .in_req_i    (in_req_i),
    .out_valid_i (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_rsp_i   (out_rsp_o),
    .pending_o   (pending),
    .fails_o     (fails)
  );

  always @(negedge clk_i) begin
    out_stall_i <= no_idle ? 1'b0 : ($urandom_range(99) < 19);
  end

  task automatic send_request(action_e act, int unsigned cnt, logic [DataW-1:0] data);
    in_req_t req;
    while (!no_idle && $urandom_range(99) < 19) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    req.action     = act;
    req.byte_count = cnt[CountW-1:0];
    req.data_in    = data;
    in_valid_i <= 1'b1;
    in_req_i   <= req;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
  endtask

  task automatic set_capacity(logic [CapW-1:0] cap);
    in_valid_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= cap;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  initial begin : stimulus
    action_e         act;
    int unsigned     cnt;
    int unsigned     push_pct;
    logic [DataW-1:0] data;
    logic [CapW-1:0] cap;

    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    send_request(ACT_POP, 1, '0);
    send_request(ACT_POP, 0, '0);
    send_request(ACT_PUSH, 0, '1);
    send_request(ACT_PUSH, 9, '1);
    send_request(ACT_PUSH, 15, '1);
    send_request(ACT_PUSH, 8, '1);
    send_request(ACT_PUSH, 1, '0);
    send_request(ACT_POP, 15, '0);
    send_request(ACT_POP, 0, '0);
    send_request(ACT_POP, 8, '0);
    send_request(ACT_POP, 2, '0);
    send_request(ACT_POP, 1, '0);

    set_capacity(9'd5);
    send_request(ACT_PUSH, 6, 64'h0123_4567_89ab_cdef);
    send_request(ACT_PUSH, 3, 64'h0123_4567_89ab_cdef);
    send_request(ACT_PUSH, 3, 64'hfedc_ba98_7654_3210);
    send_request(ACT_PUSH, 2, 64'h5a5a_a5a5_c3c3_3c3c);
    send_request(ACT_POP, 4, '0);
    send_request(ACT_PUSH, 4, 64'h8000_0000_1122_3344);
    send_request(ACT_POP, 5, '0);

    set_capacity(9'd0);
    send_request(ACT_PUSH, 2, 64'h0000_0000_0000_ff77);
    send_request(ACT_PUSH, 1, 64'h0000_0000_0000_0081);
    send_request(ACT_PUSH, 1, 64'h0000_0000_0000_0042);
    send_request(ACT_POP, 1, '0);

    for (int p = 0; p < NumPhases; p++) begin
      cap = (p == 5) ? 9'($urandom_range(9, 255)) : phase_cap[p];
      set_capacity(cap);
      no_idle <= phase_calm[p];
      for (int i = 0; i < phase_len[p]; i++) begin
        push_pct = (i < phase_len[p] * 3 / 5) ? 75 : 25;
        data     = {$urandom, $urandom};
        act      = ($urandom_range(99) < push_pct) ? ACT_PUSH : ACT_POP;
        if ($urandom_range(99) < 10) begin
          cnt = $urandom_range(1) ? 0 : $urandom_range(9, 15);
        end else begin
          cnt = $urandom_range(1, MaxBurstDef);
        end
        send_request(act, cnt, data);
      end
      no_idle <= 1'b0;
    end

    in_valid_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
    if (fails == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin : watchdog
    #2000000;
    $display("== FAIL ==");
    $finish;
  end

endmodule

FILE: files.f
sv/brf_pkg.sv
sv/brf_lane.sv
sv/brf_merge.sv
sv/byte_ring_fifo_burst.sv
tb/sv/brf_burst_checker.sv
tb/sv/tb_byte_ring_fifo_burst.sv
